@@ rtl/core/mexp_pkg.sv @@
// Shared types for the modular exponentiation unit.
// Holds the controller state type and the controller/datapath command and status structs.
// No dependencies.
package mexp_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_REDUCE,
        S_SETUP,
        S_MUL,
        S_UPDATE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;      // capture operands
        logic red_step;  // one bit of base mod modulus
        logic mul_step;  // one bit of both modular multiplications
        logic advance;   // take new square, restart lanes
        logic upd_acc;   // consume one exponent bit
        logic finish;    // register the result
    } t_dp_cmd;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_hi_zero;
    } t_dp_status;

endpackage

@@ rtl/core/modular_exponentiation_unit.sv @@
// A zero modulus or zero exponent goes from PREP straight to FINISH; otherwise the flow runs PREP,
// REDUCE, SETUP, then MUL and UPDATE once per exponent bit up to the top set one, then FINISH.
// One transaction at a time; busy is high throughout.
// busy drops with the strobe; two lanes, one multiplier bit a cycle.
// Reset (synchronous, active low) returns the controller to idle and drops the strobe.
// The result strobe is one cycle wide; the receiver cannot stall.
module modular_exponentiation_unit #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_base_value,
    input  logic [WIDTH-1:0] i_exponent_value,
    input  logic [WIDTH-1:0] i_modulus_value,
    output logic             o_result_valid,
    output logic [WIDTH-1:0] o_power_result,
    output logic             o_zero_modulus_error
);
    import mexp_pkg::*;

    // Flow per transaction:
    //   PREP    check for zero modulus / zero exponent (both finish at once)
    //   REDUCE  base mod modulus, one bit a cycle, in the square lane
    //   SETUP   reduced base becomes the running square
    //   MUL     acc*sq and sq*sq in parallel over all WIDTH multiplier bits of sq
    //   UPDATE  keep acc product if exponent bit set, take new square, shift exponent
    //   FINISH  register result and error flag; the strobe follows in the next cycle
    t_dp_cmd    cmd;
    t_dp_status status;

    mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    mexp_datapath #(.WIDTH(WIDTH)) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_base_value         (i_base_value),
        .i_exponent_value     (i_exponent_value),
        .i_modulus_value      (i_modulus_value),
        .o_power_result       (o_power_result),
        .o_zero_modulus_error (o_zero_modulus_error)
    );

endmodule

@@ rtl/core/mexp_lane.sv @@
// One double-and-add modular multiplication lane: part = 2*part + bit*x mod m per step.
// Requires x < m (or x = 1); uses no package items.
module mexp_lane #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_clr,
    input  logic             i_step,
    input  logic             i_bit,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_mod,
    output logic [WIDTH-1:0] o_part
);

    logic [WIDTH-1:0] r_part;
    logic [WIDTH-1:0] n_part;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] mod1;
    logic [WIDTH+1:0] mod2;

    // sum < 3m, so one of two parallel subtractions brings it back below m
    always_comb begin
        sum  = {1'b0, r_part, 1'b0} + {2'b00, (i_bit ? i_x : {WIDTH{1'b0}})};
        mod1 = {2'b00, i_mod};
        mod2 = {1'b0, i_mod, 1'b0};
        if (sum >= mod2) begin
            n_part = WIDTH'(sum - mod2);
        end else if (sum >= mod1) begin
            n_part = WIDTH'(sum - mod1);
        end else begin
            n_part = sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_part <= '0;
        end else if (i_step) begin
            r_part <= n_part;
        end
    end

    assign o_part = r_part;

    a_clr_zero: assert property (@(posedge i_clk) i_clr |=> r_part == '0)
        else $error("lane partial not cleared");
    a_reduced: assert property (@(posedge i_clk)
        (i_step && !i_clr && r_part < i_mod) |=> (r_part < i_mod || $changed(i_mod)))
        else $error("lane partial left the residue range");

endmodule

@@ rtl/core/mexp_datapath.sv @@
// Datapath of the modular exponentiation unit: operand registers and two multiply lanes.
// Depends on mexp_pkg and mexp_lane.
module mexp_datapath #(
    parameter int WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mexp_pkg::t_dp_cmd      i_cmd,
    output mexp_pkg::t_dp_status   o_status,
    input  logic [WIDTH-1:0]       i_base_value,
    input  logic [WIDTH-1:0]       i_exponent_value,
    input  logic [WIDTH-1:0]       i_modulus_value,
    output logic [WIDTH-1:0]       o_power_result,
    output logic                   o_zero_modulus_error
);
    import mexp_pkg::*;

    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_expo;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_sq;
    logic             r_exp0;
    logic [WIDTH-1:0] r_result;
    logic             r_err;

    logic [WIDTH-1:0] acc_part;
    logic [WIDTH-1:0] sq_part;
    logic [WIDTH-1:0] sq_x;
    logic             lane_clr;

    assign lane_clr = i_cmd.load | i_cmd.advance;
    // while reducing the base, the square lane runs a restoring division (x = 1)
    assign sq_x     = i_cmd.red_step ? ONE : r_sq;

    mexp_lane #(.WIDTH(WIDTH)) u_acc_lane (
        .i_clk  (i_clk),
        .i_clr  (lane_clr),
        .i_step (i_cmd.mul_step),
        .i_bit  (r_y[WIDTH-1]),
        .i_x    (r_acc),
        .i_mod  (r_mod),
        .o_part (acc_part)
    );

    mexp_lane #(.WIDTH(WIDTH)) u_sq_lane (
        .i_clk  (i_clk),
        .i_clr  (lane_clr),
        .i_step (i_cmd.red_step | i_cmd.mul_step),
        .i_bit  (r_y[WIDTH-1]),
        .i_x    (sq_x),
        .i_mod  (r_mod),
        .o_part (sq_part)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod  <= i_modulus_value;
            r_expo <= i_exponent_value;
            r_y    <= i_base_value;
            r_acc  <= (i_modulus_value == ONE) ? '0 : ONE;
            r_exp0 <= (i_exponent_value == '0);
        end else if (i_cmd.red_step || i_cmd.mul_step) begin
            r_y <= {r_y[WIDTH-2:0], 1'b0};
        end else if (i_cmd.advance) begin
            r_sq <= sq_part;
            r_y  <= sq_part;
            if (i_cmd.upd_acc) begin
                if (r_expo[0]) begin
                    r_acc <= acc_part;
                end
                r_expo <= {1'b0, r_expo[WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result <= '0;
            r_err    <= 1'b0;
        end else if (i_cmd.finish) begin
            r_err <= (r_mod == '0);
            if (r_mod == '0) begin
                r_result <= '0;
            end else if (r_exp0) begin
                r_result <= ONE;
            end else begin
                r_result <= r_acc;
            end
        end
    end

    assign o_status.mod_zero    = (r_mod == '0);
    assign o_status.exp_zero    = (r_expo == '0);
    assign o_status.exp_hi_zero = (r_expo[WIDTH-1:1] == '0);

    assign o_power_result       = r_result;
    assign o_zero_modulus_error = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_result == '0)
        else $error("error flagged with nonzero result");

endmodule

@@ rtl/core/mexp_ctrl.sv @@
// Controller of the modular exponentiation unit: sequencing FSM and bit counter.
// Depends on mexp_pkg.
module mexp_ctrl #(
    parameter int WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 o_result_valid,
    input  mexp_pkg::t_dp_status i_status,
    output mexp_pkg::t_dp_cmd    o_cmd
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WIDTH);

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            r_valid;
    logic            last_bit;

    assign last_bit = (r_cnt == CW'(WIDTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_PREP;
            end
            S_PREP: begin
                if (i_status.mod_zero || i_status.exp_zero) n_state = S_FINISH;
                else                                        n_state = S_REDUCE;
            end
            S_REDUCE: begin
                if (last_bit) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (last_bit) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.exp_hi_zero) n_state = S_FINISH;
                else                      n_state = S_MUL;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:   o_cmd.load     = start;
            S_REDUCE: o_cmd.red_step = 1'b1;
            S_SETUP:  o_cmd.advance  = 1'b1;
            S_MUL:    o_cmd.mul_step = 1'b1;
            S_UPDATE: begin
                o_cmd.advance = 1'b1;
                o_cmd.upd_acc = 1'b1;
            end
            S_FINISH: o_cmd.finish   = 1'b1;
            default:  o_cmd          = '0;
        endcase
    end

    assign n_cnt = (r_state == S_REDUCE || r_state == S_MUL) ? r_cnt + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= (r_state == S_FINISH);
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_FINISH))
        else $error("result strobe without finish");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
    a_cnt_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP || r_state == S_UPDATE) |=> r_cnt == '0)
        else $error("bit counter not restarted for multiply");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for modular_exponentiation_unit (rtl/core, WIDTH = 64).
// Queue-fed command driver and strobe monitor, checked against an in-bench
// square-and-multiply model built on exact 128-bit products.
module tb_top;

    localparam int WIDTH    = 64;
    localparam int IDLE_PCT = 34;   // percent of free cycles the driver sits out

    typedef struct packed {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
    } operand_t;

    typedef struct packed {
        logic [WIDTH-1:0] power;
        logic             zero_mod;
    } power_t;

    // DUT connections; every input has a known value from time zero
    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             start            = 1'b0;
    logic             busy;
    logic [WIDTH-1:0] i_base_value     = '0;
    logic [WIDTH-1:0] i_exponent_value = '0;
    logic [WIDTH-1:0] i_modulus_value  = '0;
    logic             o_result_valid;
    logic [WIDTH-1:0] o_power_result;
    logic             o_zero_modulus_error;

    // Operands waiting to be issued, and powers the monitor still owes us
    operand_t operand_queue[$];
    power_t   expected_powers[$];

    int       error_count    = 0;
    int       accepted_count = 0;
    logic     take_next;
    logic     sit_out;
    operand_t next_op;
    power_t   predicted;
    power_t   expected_power;

    modular_exponentiation_unit #(
        .WIDTH(WIDTH)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_base_value        (i_base_value),
        .i_exponent_value    (i_exponent_value),
        .i_modulus_value     (i_modulus_value),
        .o_result_valid      (o_result_valid),
        .o_power_result      (o_power_result),
        .o_zero_modulus_error(o_zero_modulus_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model: exact (a * b) mod m using a double-width product, then
    // right-to-left square-and-multiply over the exponent bits.
    // ------------------------------------------------------------------
    function automatic logic [WIDTH-1:0] mul_reduce(input logic [WIDTH-1:0] a,
                                                    input logic [WIDTH-1:0] b,
                                                    input logic [WIDTH-1:0] m);
        logic [2*WIDTH-1:0] prod;
        logic [2*WIDTH-1:0] rem;
        prod = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
        rem  = prod % {{WIDTH{1'b0}}, m};
        return rem[WIDTH-1:0];
    endfunction

    function automatic power_t mod_power(input operand_t op);
        power_t           res;
        logic [WIDTH-1:0] acc;
        logic [WIDTH-1:0] sq;
        logic [WIDTH-1:0] e;
        acc = 1;
        sq  = op.base;
        e   = op.exponent;
        // Zero modulus wins over everything, including a zero exponent
        if (op.modulus == 0) begin
            res.power    = '0;
            res.zero_mod = 1'b1;
            return res;
        end
        // acc stays at an unreduced 1 when the exponent is zero
        while (e != 0) begin
            if (e[0])
                acc = mul_reduce(acc, sq, op.modulus);
            sq = mul_reduce(sq, sq, op.modulus);
            e  = e >> 1;
        end
        res.power    = acc;
        res.zero_mod = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_item(input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] e,
                            input logic [WIDTH-1:0] m);
        operand_t op;
        op.base     = b;
        op.exponent = e;
        op.modulus  = m;
        operand_queue.push_back(op);
    endtask

    // Exponent bit length is spread out so run time stays reasonable while
    // full 64-bit exponents still show up; bases and moduli span all sizes.
    task automatic add_random_item();
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] e;
        logic [WIDTH-1:0] m;
        int               pick;
        b = rand64();
        if ($urandom_range(3) == 0)
            b = b >> $urandom_range(63);
        e = rand64() >> $urandom_range(63);
        if ($urandom_range(24) == 0)
            e = '0;
        pick = $urandom_range(19);
        if (pick == 0) begin
            m = '0;
        end else if (pick == 1) begin
            m = 1;
        end else if (pick < 6) begin
            m = rand64() >> $urandom_range(62);
        end else begin
            m = rand64();
        end
        if (pick > 1 && m == 0)
            m = 3;
        add_item(b, e, m);
    endtask

    // ------------------------------------------------------------------
    // Driver: a transaction is taken at an edge where start is high and
    // busy is low. Once an operand is presented it is held until taken;
    // otherwise each free cycle may be skipped at random. Accepted items
    // 60..99 run with no skipping so results come back to back.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take_next = 1'b0;
            if (start && !busy) begin
                next_op.base     = i_base_value;
                next_op.exponent = i_exponent_value;
                next_op.modulus  = i_modulus_value;
                predicted        = mod_power(next_op);
                expected_powers.push_back(predicted);
                accepted_count++;
                take_next = 1'b1;
            end else if (!start) begin
                take_next = 1'b1;
            end

            if (take_next) begin
                sit_out = ($urandom_range(99) < IDLE_PCT)
                          && !(accepted_count >= 60 && accepted_count < 100);
                if (operand_queue.size() != 0 && !sit_out) begin
                    next_op          = operand_queue.pop_front();
                    i_base_value     <= next_op.base;
                    i_exponent_value <= next_op.exponent;
                    i_modulus_value  <= next_op.modulus;
                    start            <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: the strobe lasts one cycle and cannot be stalled, so every
    // high strobe at an edge is one result transaction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected result: power %h, zero-modulus flag %b",
                         $time, o_power_result, o_zero_modulus_error);
                error_count++;
            end else begin
                expected_power = expected_powers.pop_front();
                if (o_power_result !== expected_power.power) begin
                    $display("%0t: power mismatch: expected %h, actual %h",
                             $time, expected_power.power, o_power_result);
                    error_count++;
                end
                if (o_zero_modulus_error !== expected_power.zero_mod) begin
                    $display("%0t: zero-modulus flag mismatch: expected %b, actual %b",
                             $time, expected_power.zero_mod, o_zero_modulus_error);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Directed corners
        add_item(64'd2, 64'd10, 64'd1000);                 // plain case
        add_item(64'd5, 64'd0, 64'd1);                     // zero exponent, unreduced 1
        add_item(64'd0, 64'd0, 64'd7);                     // zero base, zero exponent
        add_item(64'd0, 64'd3, 64'd7);                     // zero base
        add_item(64'd9, 64'd0, 64'd0);                     // zero modulus, zero exponent
        add_item('1, '1, 64'd0);                           // zero modulus, big operands
        add_item(64'd12345, 64'd5, 64'd1);                 // modulus one
        add_item('1, 64'd1, 64'd1);
        add_item(64'd1000, 64'd1, 64'd7);                  // base above modulus
        add_item(64'd77, 64'd3, 64'd77);                   // base equal to modulus
        add_item(64'hFFFF_FFFF_FFFF_FFC4, 64'd2,
                 64'hFFFF_FFFF_FFFF_FFC5);                 // (m-1)^2 = 1
        add_item('1, '1, '1);                              // all ones everywhere
        add_item('1, '1, 64'hFFFF_FFFF_FFFF_FFC5);         // largest 64-bit prime
        add_item(64'd3, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFC5);                 // only the top exponent bit
        add_item(64'h8000_0000_0000_0001, '1, 64'd2);      // odd base, modulus two
        add_item(64'hDEAD_BEEF_0123_4567, 64'd0, '1);      // zero exponent, huge modulus
        add_item(64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h8000_0000_0000_0000);                 // power-of-two modulus
        add_item(64'hFEDC_BA98_7654_3210, 64'h5555_5555_5555_5555,
                 64'h7FFF_FFFF_FFFF_FFFF);
        add_item(64'd2, 64'd63, '1);
        for (int n = 0; n < 121; n++)
            add_random_item();

        // Reset held low at first, then released for good
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything issued, everything answered, then a short tail
        while (operand_queue.size() != 0 || start || expected_powers.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0 && expected_powers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run of all ~140 items
    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/mexp_pkg.sv
rtl/core/mexp_lane.sv
rtl/core/mexp_datapath.sv
rtl/core/mexp_ctrl.sv
rtl/core/modular_exponentiation_unit.sv
verif/tb_top.sv
